[rtl/core/sorted_name_directory_search_assert.svh]
// Assertion macros shared by the directory search checkers.
// Depends on signals named clk and arst_n in the module that expands them.
`ifndef SORTED_NAME_DIRECTORY_SEARCH_ASSERT_SVH
`define SORTED_NAME_DIRECTORY_SEARCH_ASSERT_SVH

// same-cycle implication, held off during reset
`define SNDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define SNDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/snds_pkg.sv]
// Shared types and codes for the sorted name directory search block.
// No dependencies; used by the controller, datapath, top level and checker.
`default_nettype none

package snds_pkg;

	// request opcodes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// register map: word index taken from paddr[2]
	localparam logic REG_ENTRY_COUNT = 1'b0;

	localparam int NAME_BYTES = 12;
	localparam int NAME_BITS  = 8 * NAME_BYTES;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} snds_state_t;

	// controller to datapath
	typedef struct packed {
		logic wr;
		logic start;
		logic probe;
		logic cmp;
		logic load_out;
	} snds_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic start_miss;
		logic last_probe;
		logic cmp_eq;
	} snds_status_t;

endpackage

`default_nettype wire

[rtl/core/snds_ctrl.sv]
// Search sequencer: accepts requests, steps the binary search, hands off results.
// Depends on snds_pkg for state, command and status types.
`default_nettype none

module snds_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  opcode,
	input  wire logic                  out_ready,
	input  wire snds_pkg::snds_status_t status,
	output logic                       in_ready,
	output logic                       out_valid,
	output snds_pkg::snds_cmd_t        cmd
);

	snds_pkg::snds_state_t state_q, state_d;
	logic out_valid_q;

	// state register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= snds_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			snds_pkg::ST_IDLE: begin
				if (in_valid && opcode == snds_pkg::OP_LOOKUP) begin
					state_d = status.start_miss ? snds_pkg::ST_DONE : snds_pkg::ST_PROBE;
				end
			end
			snds_pkg::ST_PROBE: begin
				state_d = snds_pkg::ST_CMP;
			end
			snds_pkg::ST_CMP: begin
				if (status.last_probe || status.cmp_eq) begin
					state_d = snds_pkg::ST_DONE;
				end else begin
					state_d = snds_pkg::ST_PROBE;
				end
			end
			snds_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = snds_pkg::ST_IDLE;
				end
			end
			default: state_d = snds_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		in_ready     = (state_q == snds_pkg::ST_IDLE);
		cmd.wr       = in_ready && in_valid && (opcode == snds_pkg::OP_WRITE);
		cmd.start    = in_ready && in_valid && (opcode == snds_pkg::OP_LOOKUP);
		cmd.probe    = (state_q == snds_pkg::ST_PROBE);
		cmd.cmp      = (state_q == snds_pkg::ST_CMP);
		cmd.load_out = (state_q == snds_pkg::ST_DONE) && (!out_valid_q || out_ready);
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/snds_datapath.sv]
// Directory memory, search bounds, name comparator and result register.
// Depends on snds_pkg for command and status types and name sizes.
`default_nettype none

module snds_datapath #(
	parameter int DIR_DEPTH = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire snds_pkg::snds_cmd_t   cmd,
	input  wire logic [10:0]           entry_count,
	input  wire logic [9:0]            entry_index,
	input  wire logic [63:0]           name_head,
	input  wire logic [31:0]           name_tail,
	input  wire logic                  name_too_long,
	output snds_pkg::snds_status_t     status,
	output logic                       found,
	output logic [9:0]                 match_index
);

	localparam int AW = $clog2(DIR_DEPTH);
	localparam int CW = AW + 1;
	localparam int NB = snds_pkg::NAME_BYTES;

	logic [snds_pkg::NAME_BITS-1:0] dir_mem_q [DIR_DEPTH];
	logic [snds_pkg::NAME_BITS-1:0] rd_q;
	logic [snds_pkg::NAME_BITS-1:0] key_q;

	logic [AW-1:0] lo_q, hi_q, idx_q, where_q;
	logic          last_q, hit_q;
	logic          found_q;
	logic [9:0]    match_q;

	logic [CW-1:0] count_sat;
	logic [AW:0]   bound_sum;
	logic [AW-1:0] mid;
	logic          wr_in_range;
	logic          cmp_eq, cmp_lt;

	// count clipped to the store depth
	assign count_sat = (32'(entry_count) > 32'(DIR_DEPTH)) ? CW'(DIR_DEPTH) : CW'(entry_count);
	assign wr_in_range = 32'(entry_index) < 32'(DIR_DEPTH);

	// probe point; equals lo once the bounds meet
	assign bound_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = bound_sum[AW:1];

	// directory store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr && wr_in_range) begin
			dir_mem_q[AW'(entry_index)] <= {name_head, name_tail};
		end
		if (cmd.probe) begin
			rd_q <= dir_mem_q[mid];
		end
	end

	// strcmp on unsigned bytes, stopping at the first NUL
	always_comb begin
		logic       live;
		logic [7:0] x, y;
		live   = 1'b1;
		cmp_eq = 1'b1;
		cmp_lt = 1'b0;
		for (int i = 0; i < NB; i++) begin
			x = key_q[8*(NB-1-i) +: 8];
			y = rd_q[8*(NB-1-i) +: 8];
			if (live && x != y) begin
				cmp_eq = 1'b0;
				cmp_lt = cmp_lt | (x < y);
			end
			live = live && (x == y) && (x != 8'd0);
		end
	end

	// key and payload-side search registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= {name_head, name_tail};
			lo_q  <= '0;
			hi_q  <= AW'(count_sat - CW'(1));
		end else if (cmd.cmp && !cmp_eq && !last_q) begin
			if (cmp_lt) begin
				hi_q <= idx_q;
			end else begin
				lo_q <= idx_q + AW'(1);
			end
		end
		if (cmd.probe) begin
			idx_q <= mid;
		end
		if (cmd.start) begin
			where_q <= '0;
		end else if (cmd.cmp && cmp_eq) begin
			where_q <= idx_q;
		end
		if (cmd.load_out) begin
			found_q <= hit_q;
			match_q <= hit_q ? 10'(where_q) : 10'd0;
		end
	end

	// search control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (cmd.probe) begin
				last_q <= (lo_q == hi_q);
			end
			if (cmd.start) begin
				hit_q <= 1'b0;
			end else if (cmd.cmp && cmp_eq) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign status.start_miss = name_too_long || (count_sat == '0);
	assign status.last_probe = last_q;
	assign status.cmp_eq     = cmp_eq;
	assign found             = found_q;
	assign match_index       = match_q;

endmodule

`default_nettype wire

[rtl/core/sorted_name_directory_search.sv]
// Sorted name directory search. A write request stores one 12-byte name in a
// slot. A lookup request binary-searches the first entry_count slots (which
// must be written and sorted ascending) and returns found and the slot index.
// Each probe is a registered read of the directory memory followed by the
// 12-byte compare, and a lookup ends early when a probe matches; a name
// flagged too long or an empty directory skips the search and answers a miss.
// The result sits in an output register, and the block takes new requests
// while it waits.
// Register 0 (byte address 0): entry_count, clipped to DIR_DEPTH on use.
`default_nettype none

module sorted_name_directory_search #(
	parameter int DIR_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic [9:0]  entry_index,
	input  wire logic [63:0] name_head,
	input  wire logic [31:0] name_tail,
	input  wire logic        name_too_long,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [9:0]       match_index,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [10:0]            entry_count_q;
	snds_pkg::snds_cmd_t    cmd;
	snds_pkg::snds_status_t status;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == snds_pkg::REG_ENTRY_COUNT) begin
			entry_count_q <= pwdata[10:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == snds_pkg::REG_ENTRY_COUNT) ? {21'd0, entry_count_q} : 32'd0;

	snds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.out_ready (out_ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	snds_datapath #(
		.DIR_DEPTH (DIR_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.entry_count   (entry_count_q),
		.entry_index   (entry_index),
		.name_head     (name_head),
		.name_tail     (name_tail),
		.name_too_long (name_too_long),
		.status        (status),
		.found         (found),
		.match_index   (match_index)
	);

endmodule

`default_nettype wire

[rtl/core/snds_checker.sv]
// Port-level checks for the directory search block, bound to the top level.
// Depends on sorted_name_directory_search_assert.svh for the assertion macros.
`default_nettype none

`include "sorted_name_directory_search_assert.svh"

module snds_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       opcode,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       found,
	input wire logic [9:0] match_index
);

	// a stalled result holds
	`SNDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(match_index), "result changed while stalled")

	// a miss carries a zero index
	`SNDS_ASSERT_NOW(a_miss_zero, out_valid && !found, match_index == 10'd0, "miss with nonzero index")

	// a lookup keeps the request side busy for at least the next cycle
	`SNDS_ASSERT_NEXT(a_lookup_busy, in_valid && in_ready && opcode == snds_pkg::OP_LOOKUP, !in_ready, "request taken during lookup")

	// a write request produces no result
	`SNDS_ASSERT_NEXT(a_write_silent, in_valid && in_ready && opcode == snds_pkg::OP_WRITE && !out_valid, !out_valid, "write produced a result")

endmodule

bind sorted_name_directory_search snds_checker u_snds_checker (.*);

`default_nettype wire
